@@ sv/base32_stream_encoder_top_defines.svh @@
// assertion macros for the files that check their own logic
`ifndef BASE32_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE32_STREAM_ENCODER_TOP_DEFINES_SVH

// combinational condition that must hold at every edge outside reset
`define B32_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// implication checked in the cycle after the antecedent, outside reset
`define B32_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/b32enc_pkg.sv @@
package b32enc_pkg;

  localparam int ByteW         = 8;
  localparam int GroupBytes    = 5;
  localparam int GroupW        = ByteW * GroupBytes;
  localparam int HeldW         = ByteW * (GroupBytes - 1);
  localparam int CntW          = 3;
  localparam int SymW          = 5;
  localparam int CharsPerGroup = 8;
  localparam int IdxW          = 3;
  localparam int PadW          = 3;
  localparam logic [ByteW-1:0] PadChar = 8'h3D;

  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  localparam int CfgAddrW  = 6;
  localparam int CfgDataW  = 64;
  localparam int AlphaWords = 4;

  // register indexes, taken from paddr[5:3]
  localparam logic [2:0] RegUseDefault = 3'd0;
  localparam logic [2:0] RegAlpha0     = 3'd1;
  localparam logic [2:0] RegAlpha1     = 3'd2;
  localparam logic [2:0] RegAlpha2     = 3'd3;
  localparam logic [2:0] RegAlpha3     = 3'd4;

  typedef struct packed {
    logic [GroupW-1:0] group;  // left-aligned, zero-filled
    logic [PadW-1:0]   npad;
    logic              eom;
  } grp_t;

  typedef struct packed {
    logic                                use_default;
    logic [AlphaWords-1:0][CfgDataW-1:0] alphabet;
  } cfg_t;

  function automatic logic [ByteW-1:0] std_char(logic [SymW-1:0] s);
    logic [ByteW-1:0] c;
    if (s < 5'd26) begin
      c = 8'h41 + {3'b000, s};
    end else begin
      c = 8'h32 + ({3'b000, s} - 8'd26);
    end
    return c;
  endfunction

  function automatic logic [PadW-1:0] pad_count(logic [CntW-1:0] cnt);
    logic [PadW-1:0] p;
    case (cnt)
      3'd1:    p = 3'd6;
      3'd2:    p = 3'd4;
      3'd3:    p = 3'd3;
      3'd4:    p = 3'd1;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

@@ sv/base32_stream_encoder_top.sv @@
// channel   direction  data                       side bits
// s_axis    in         tdata[7:0] = data_byte     tlast = end_of_message
// m_axis    out        tdata[7:0] = out_char      tlast = last_char
// apb       in/out     64-bit registers at 8*i    pready tied high
//
// a byte is taken every cycle while the group queue has room; the character
// side gives one character per cycle while the output is not stalled, eight per
// group of five bytes, so on a long message the character output sets the pace.
// a group passes the queue, then the group register, then the output register.
// reset clears the gathering state, the queue and the output valid flag.
// a stalled output holds its character; the queue lets input continue meanwhile.
`include "base32_stream_encoder_top_defines.svh"

module base32_stream_encoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [7:0] data_byte
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // [7:0] out_char
  output logic                                m_axis_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [b32enc_pkg::CfgAddrW-1:0]     paddr,
  input  logic [b32enc_pkg::CfgDataW-1:0]     pwdata,
  output logic [b32enc_pkg::CfgDataW-1:0]     prdata,
  output logic                                pready
);

  b32enc_pkg::cfg_t              cfg_q, cfg_d;
  logic [2:0]                    reg_idx;
  logic                          cfg_wr;

  b32enc_pkg::grp_t              q_wdata;
  b32enc_pkg::grp_t              q_rdata;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_full;
  logic                          q_empty;
  logic [b32enc_pkg::CntW-1:0]   held_cnt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        b32enc_pkg::RegUseDefault: cfg_d.use_default = pwdata[0];
        b32enc_pkg::RegAlpha0:     cfg_d.alphabet[0] = pwdata;
        b32enc_pkg::RegAlpha1:     cfg_d.alphabet[1] = pwdata;
        b32enc_pkg::RegAlpha2:     cfg_d.alphabet[2] = pwdata;
        b32enc_pkg::RegAlpha3:     cfg_d.alphabet[3] = pwdata;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      b32enc_pkg::RegUseDefault: prdata = {63'd0, cfg_q.use_default};
      b32enc_pkg::RegAlpha0:     prdata = cfg_q.alphabet[0];
      b32enc_pkg::RegAlpha1:     prdata = cfg_q.alphabet[1];
      b32enc_pkg::RegAlpha2:     prdata = cfg_q.alphabet[2];
      b32enc_pkg::RegAlpha3:     prdata = cfg_q.alphabet[3];
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_default <= 1'b1;
      cfg_q.alphabet    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  b32enc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_wdata_o     (q_wdata),
    .held_cnt_o    (held_cnt)
  );

  b32enc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  b32enc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_rdata_i     (q_rdata),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `B32_ASSERT_ALWAYS(a_no_push_full, !(q_push && q_full), "group pushed into a full queue")
  `B32_ASSERT_ALWAYS(a_no_pop_empty, !(q_pop && q_empty), "group popped from an empty queue")
  `B32_ASSERT_ALWAYS(a_held_range, held_cnt <= 3'd4, "more than four bytes held")
  `B32_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_empty, "pushed group not visible in queue")

endmodule

@@ sv/b32enc_front.sv @@
module b32enc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [b32enc_pkg::ByteW-1:0]    s_axis_tdata,
  input  logic                            s_axis_tlast,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output b32enc_pkg::grp_t                q_wdata_o,
  output logic [b32enc_pkg::CntW-1:0]     held_cnt_o
);

  logic [b32enc_pkg::HeldW-1:0]  held_q, held_d;
  logic [b32enc_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [b32enc_pkg::CntW-1:0]   cnt_inc;
  logic [b32enc_pkg::GroupW-1:0] group_raw;
  logic [b32enc_pkg::GroupW-1:0] group_aligned;
  logic                          accept;
  logic                          done;

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cnt_inc       = cnt_q + 3'd1;
  assign group_raw     = {held_q, s_axis_tdata};
  assign done          = (cnt_inc == 3'(b32enc_pkg::GroupBytes)) || s_axis_tlast;

  // move the bytes present up to the top of the 40-bit group
  always_comb begin
    case (cnt_inc)
      3'd1:    group_aligned = group_raw << 32;
      3'd2:    group_aligned = group_raw << 24;
      3'd3:    group_aligned = group_raw << 16;
      3'd4:    group_aligned = group_raw << 8;
      default: group_aligned = group_raw;
    endcase
  end

  assign q_push_o        = accept && done;
  assign q_wdata_o.group = group_aligned;
  assign q_wdata_o.npad  = b32enc_pkg::pad_count(cnt_inc);
  assign q_wdata_o.eom   = s_axis_tlast;
  assign held_cnt_o      = cnt_q;

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (done) begin
        held_d = '0;
        cnt_d  = '0;
      end else begin
        held_d = group_raw[b32enc_pkg::HeldW-1:0];
        cnt_d  = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ sv/b32enc_fifo.sv @@
module b32enc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b32enc_pkg::grp_t wdata_i,
  input  logic             pop_i,
  output b32enc_pkg::grp_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  b32enc_pkg::grp_t                mem_q [b32enc_pkg::QDepth];
  logic [b32enc_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [b32enc_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [b32enc_pkg::QCntW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == b32enc_pkg::QCntW'(b32enc_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == b32enc_pkg::QPtrW'(b32enc_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == b32enc_pkg::QPtrW'(b32enc_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ sv/b32enc_back.sv @@
module b32enc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  b32enc_pkg::cfg_t             cfg_i,
  input  b32enc_pkg::grp_t             q_rdata_i,
  input  logic                         q_empty_i,
  output logic                         q_pop_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [b32enc_pkg::ByteW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);

  logic                          active_q, active_d;
  logic [b32enc_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [b32enc_pkg::GroupW-1:0] grp_q, grp_d;
  logic [b32enc_pkg::PadW-1:0]   npad_q, npad_d;
  logic                          eom_q, eom_d;
  logic                          ovalid_q, ovalid_d;
  logic [b32enc_pkg::ByteW-1:0]  ochar_q, ochar_d;
  logic                          olast_q, olast_d;

  logic                          out_free;
  logic                          advance;
  logic                          finish;
  logic                          load;
  logic                          is_pad;
  logic [b32enc_pkg::SymW-1:0]   sym;
  logic [b32enc_pkg::ByteW-1:0]  mapped;
  logic [3:0]                    pad_sum;

  assign out_free = !ovalid_q || m_axis_tready;
  assign advance  = active_q && out_free;
  assign finish   = advance && (idx_q == 3'(b32enc_pkg::CharsPerGroup - 1));
  assign load     = !q_empty_i && (!active_q || finish);
  assign q_pop_o  = load;

  // group shifts left one symbol per character, so the current symbol is on top
  assign sym     = grp_q[b32enc_pkg::GroupW-1 -: b32enc_pkg::SymW];
  assign pad_sum = {1'b0, idx_q} + {1'b0, npad_q};
  assign is_pad  = pad_sum >= 4'(b32enc_pkg::CharsPerGroup);

  always_comb begin
    if (cfg_i.use_default) begin
      mapped = b32enc_pkg::std_char(sym);
    end else begin
      mapped = cfg_i.alphabet[sym[4:3]][{sym[2:0], 3'b000} +: b32enc_pkg::ByteW];
    end
  end

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    grp_d    = grp_q;
    npad_d   = npad_q;
    eom_d    = eom_q;
    if (load) begin
      active_d = 1'b1;
      idx_d    = '0;
      grp_d    = q_rdata_i.group;
      npad_d   = q_rdata_i.npad;
      eom_d    = q_rdata_i.eom;
    end else if (advance) begin
      active_d = !finish;
      idx_d    = idx_q + 1'b1;
      grp_d    = grp_q << b32enc_pkg::SymW;
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    if (advance) begin
      ovalid_d = 1'b1;
      ochar_d  = is_pad ? b32enc_pkg::PadChar : mapped;
      olast_d  = eom_q && (idx_q == 3'(b32enc_pkg::CharsPerGroup - 1));
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q   <= grp_d;
    npad_q  <= npad_d;
    eom_q   <= eom_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = ochar_q;
  assign m_axis_tlast  = olast_q;

endmodule
